[hdl/srht_pkg.sv]
// shared types and constants for the search result hash table
`timescale 1ns / 1ps
package srht_pkg;

	localparam int INDEX_BITS_DEF = 12;
	localparam int KEY_W          = 64;
	localparam int SCORE_W        = 16;
	localparam int DEPTH_W        = 8;
	localparam int SLOT_DEPTH_W   = 7;
	localparam int BOUND_W        = 2;
	localparam int MOVE_W         = 16;
	localparam int S_TDATA_W      = 144;
	localparam int M_TDATA_W      = 40;

	localparam logic OP_PROBE = 1'b0;
	localparam logic OP_STORE = 1'b1;

	localparam logic [BOUND_W-1:0] BOUND_EXACT = 2'd0;
	localparam logic [BOUND_W-1:0] BOUND_LOWER = 2'd1;
	localparam logic [BOUND_W-1:0] BOUND_UPPER = 2'd2;

	// input transaction, last declared field (position_key) in the lowest bits
	typedef struct packed {
		logic [5:0]              pad;
		logic [MOVE_W-1:0]       store_move;
		logic [BOUND_W-1:0]      bound_kind;
		logic signed [SCORE_W-1:0] store_score;
		logic signed [DEPTH_W-1:0] search_depth;
		logic signed [SCORE_W-1:0] beta;
		logic signed [SCORE_W-1:0] alpha;
		logic [KEY_W-1:0]        position_key;
	} in_item_t;

	typedef struct packed {
		logic [5:0]              pad;
		logic [MOVE_W-1:0]       found_move;
		logic signed [SCORE_W-1:0] found_score;
		logic                    score_usable;
		logic                    key_found;
	} out_item_t;

	typedef struct packed {
		logic [KEY_W-1:0]        key;
		logic [SCORE_W-1:0]      score;
		logic [SLOT_DEPTH_W-1:0] depth;
		logic [BOUND_W-1:0]      bound;
		logic [MOVE_W-1:0]       move;
	} slot_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EVAL
	} srht_state_t;

	typedef struct packed {
		logic clr;
		logic take;
		logic eval;
		logic commit;
	} srht_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic out_busy;
	} srht_sts_t;

endpackage

[hdl/search_result_hash_table_unit.sv]
// top level of the direct-mapped search result hash table
//
// channel  dir  signals                          content
// s        in   s_tvalid s_tready s_tdata s_tuser probe or store transaction
// m        out  m_tvalid m_tready m_tdata         one result per transaction
//
// a transaction goes through the slot read in the table ram (one write
// port, one registered read port), then compare and optional write-back of
// the same slot
// after reset a clear pass zeroes every slot (2**INDEX_BITS, 4096 at the
// default), one per cycle, with s_tready low
// the result sits in an output register; a new transaction is taken while it
// waits, and its evaluation holds until the output register is free
`timescale 1ns / 1ps
module search_result_hash_table_unit #(
	parameter int INDEX_BITS = srht_pkg::INDEX_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// position_key, alpha, beta, search_depth, store_score, bound_kind, store_move
	input  logic [srht_pkg::S_TDATA_W-1:0] s_tdata,
	// operation
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// key_found, score_usable, found_score, found_move
	output logic [srht_pkg::M_TDATA_W-1:0] m_tdata
);
	import srht_pkg::*;

	srht_cmd_t cmd;
	srht_sts_t sts;

	srht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	srht_dp #(
		.INDEX_BITS (INDEX_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule

[hdl/srht_ram.sv]
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module srht_ram #(
	parameter  int WIDTH = 8,
	parameter  int DEPTH = 16,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[hdl/srht_ctrl.sv]
// controller state machine: clear pass, accept, evaluate
`timescale 1ns / 1ps
module srht_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  srht_pkg::srht_sts_t sts,
	output srht_pkg::srht_cmd_t cmd
);
	import srht_pkg::*;

	srht_state_t state_q, state_d;
	logic        accept;

	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (!sts.out_busy) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		s_tready   = 1'b0;
		cmd        = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.take = s_tvalid;
			end
			ST_EVAL: begin
				cmd.eval   = 1'b1;
				cmd.commit = !sts.out_busy;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	a_accept_to_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> state_q == ST_EVAL)
		else $error("accepted transaction did not move to evaluation");

	a_clear_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR && sts.clr_last) |=> (state_q == ST_IDLE && !cmd.clr))
		else $error("clear pass did not end after last slot");

endmodule

[hdl/srht_dp.sv]
// datapath: transaction registers, slot ram, probe and store logic, output register
`timescale 1ns / 1ps
module srht_dp #(
	parameter int INDEX_BITS = srht_pkg::INDEX_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [srht_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [srht_pkg::M_TDATA_W-1:0] m_tdata,
	input  srht_pkg::srht_cmd_t            cmd,
	output srht_pkg::srht_sts_t            sts
);
	import srht_pkg::*;

	localparam int SLOTS = 2 ** INDEX_BITS;

	in_item_t                in_item;
	logic                    op_q;
	logic [KEY_W-1:0]        key_q;
	logic signed [SCORE_W-1:0] alpha_q, beta_q, score_q;
	logic signed [DEPTH_W-1:0] depth_q;
	logic [BOUND_W-1:0]      bound_q;
	logic [MOVE_W-1:0]       move_q;

	logic [INDEX_BITS-1:0]   clr_q;
	logic                    out_valid_q;
	out_item_t               out_q;

	logic                    ram_we;
	logic [INDEX_BITS-1:0]   ram_waddr, ram_raddr;
	slot_t                   ram_wdata, slot;

	logic                    key_hit, depth_ok, usable, write_ok;
	logic signed [SCORE_W-1:0] slot_score;
	logic [SLOT_DEPTH_W-1:0] new_depth;
	out_item_t               res;

	assign in_item = in_item_t'(s_tdata);

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q    <= s_tuser;
			key_q   <= in_item.position_key;
			alpha_q <= in_item.alpha;
			beta_q  <= in_item.beta;
			depth_q <= in_item.search_depth;
			score_q <= in_item.store_score;
			bound_q <= in_item.bound_kind;
			move_q  <= in_item.store_move;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// slot address comes straight from the bus so the read overlaps the accept
	assign ram_raddr = cmd.eval ? key_q[INDEX_BITS-1:0] : in_item.position_key[INDEX_BITS-1:0];

	srht_ram #(
		.WIDTH ($bits(slot_t)),
		.DEPTH (SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (slot)
	);

	assign slot_score = $signed(slot.score);
	assign key_hit    = (key_q != '0) && (slot.key == key_q);
	assign depth_ok   = $signed({1'b0, slot.depth}) >= depth_q;

	always_comb begin
		case (slot.bound)
			BOUND_EXACT: usable = 1'b1;
			BOUND_LOWER: usable = slot_score >= beta_q;
			BOUND_UPPER: usable = slot_score <= alpha_q;
			default:     usable = 1'b0;
		endcase
	end

	always_comb begin
		res = '0;
		if (op_q == OP_PROBE && key_hit) begin
			res.key_found  = 1'b1;
			res.found_move = slot.move;
			if (depth_ok && usable) begin
				res.score_usable = 1'b1;
				res.found_score  = slot_score;
			end
		end
	end

	// negative store depth is clamped to zero
	assign new_depth = depth_q[DEPTH_W-1] ? '0 : depth_q[SLOT_DEPTH_W-1:0];
	assign write_ok  = (slot.key == '0) || (new_depth >= slot.depth)
		|| ((slot.key == key_q) && (bound_q == BOUND_EXACT));

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = key_q[INDEX_BITS-1:0];
		ram_wdata = '0;
		if (cmd.clr) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
		end else if (cmd.commit && op_q == OP_STORE && write_ok) begin
			ram_we          = 1'b1;
			ram_wdata.key   = key_q;
			ram_wdata.score = score_q;
			ram_wdata.depth = new_depth;
			ram_wdata.bound = bound_q;
			ram_wdata.move  = move_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_q <= res;
		end
	end

	assign m_tvalid     = out_valid_q;
	assign m_tdata      = out_q;
	assign sts.clr_last = &clr_q;
	assign sts.out_busy = out_valid_q && !m_tready;

	a_commit_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || m_tready))
		else $error("result overwrote an untaken transaction");

	a_commit_shows_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> m_tvalid)
		else $error("committed result not presented");

	a_probe_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && !cmd.clr) |-> (op_q == OP_STORE && cmd.commit))
		else $error("table written outside a store commit");

endmodule

[tb/search_result_hash_table_unit_tb.sv]
// self-checking testbench for the search result hash table: probe/store traffic against a shadow table
`timescale 1ns / 1ps
module search_result_hash_table_unit_tb;
	import srht_pkg::*;

	localparam int SLOTS       = 1 << INDEX_BITS_DEF;
	localparam int CYCLE_LIMIT = 300000;
	localparam int RANDOM_OPS  = 550;

	typedef struct packed {
		logic     op;
		in_item_t fields;
	} table_op_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	// position_key, alpha, beta, search_depth, store_score, bound_kind, store_move
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	// operation
	logic                 s_tuser  = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	// key_found, score_usable, found_score, found_move
	logic [M_TDATA_W-1:0] m_tdata;

	table_op_t  pending_ops[$];
	out_item_t  expected_results[$];
	slot_t      shadow_table [0:SLOTS-1];
	logic [KEY_W-1:0] key_pool [0:23];
	int         total_ops  = 0;
	int         n_sent     = 0;
	int         errors     = 0;
	int         cycles     = 0;

	search_result_hash_table_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #6 clk = ~clk;

	// applies one transaction to the shadow table and returns the result it should give
	function automatic out_item_t tt_probe_or_store(logic op, in_item_t d);
		out_item_t r;
		slot_t     s;
		logic [INDEX_BITS_DEF-1:0] idx;
		int        req_depth;
		int        have_depth;
		int        sc;
		logic      usable;
		logic      write;
		r          = '0;
		idx        = d.position_key[INDEX_BITS_DEF-1:0];
		s          = shadow_table[idx];
		req_depth  = int'($signed(d.search_depth));
		have_depth = int'(s.depth);
		if (op == OP_PROBE) begin
			// key zero never hits, even after a store of key zero
			if (d.position_key != '0 && s.key == d.position_key) begin
				r.key_found  = 1'b1;
				r.found_move = s.move;
				sc           = int'($signed(s.score));
				usable       = 1'b0;
				if (have_depth >= req_depth) begin
					case (s.bound)
						BOUND_EXACT: usable = 1'b1;
						BOUND_LOWER: usable = sc >= int'($signed(d.beta));
						BOUND_UPPER: usable = sc <= int'($signed(d.alpha));
						default:     usable = 1'b0;
					endcase
				end
				if (usable) begin
					r.score_usable = 1'b1;
					r.found_score  = s.score;
				end
			end
		end else begin
			if (req_depth < 0)
				req_depth = 0;
			if (s.key == '0)
				write = 1'b1;
			else if (s.key == d.position_key)
				write = (req_depth >= have_depth) || (d.bound_kind == BOUND_EXACT);
			else
				write = req_depth >= have_depth;
			if (write)
				shadow_table[idx] = '{d.position_key, d.store_score, req_depth[6:0],
					d.bound_kind, d.store_move};
		end
		return r;
	endfunction

	task automatic queue_op(logic op, logic [KEY_W-1:0] key, logic [15:0] alpha,
		logic [15:0] beta, logic [7:0] depth, logic [15:0] score, logic [1:0] bound,
		logic [15:0] move);
		table_op_t t;
		t                     = '0;
		t.op                  = op;
		t.fields.position_key = key;
		t.fields.alpha        = alpha;
		t.fields.beta         = beta;
		t.fields.search_depth = depth;
		t.fields.store_score  = score;
		t.fields.bound_kind   = bound;
		t.fields.store_move   = move;
		pending_ops.push_back(t);
	endtask

	// mostly keys that share a few slots, so replacement gets exercised
	function automatic logic [KEY_W-1:0] pick_key();
		if ($urandom_range(99) < 20)
			return {$urandom, $urandom};
		return key_pool[$urandom_range(23)];
	endfunction

	function automatic int idle_phase();
		int p;
		p = (total_ops == 0) ? 0 : (n_sent * 4) / total_ops;
		return (p > 3) ? 3 : p;
	endfunction

	function automatic logic sender_pause();
		case (idle_phase())
			1:       return $urandom_range(99) < 49;
			3:       return $urandom_range(99) < 8;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic receiver_stall();
		case (idle_phase())
			2:       return $urandom_range(99) < 49;
			3:       return $urandom_range(99) < 8;
			default: return 1'b0;
		endcase
	endfunction

	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	// driver: presents queued transactions and predicts each one as it is accepted
	always @(posedge clk or negedge arst_n) begin : drive_requests
		table_op_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_results.push_back(tt_probe_or_store(s_tuser, in_item_t'(s_tdata)));
				n_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_ops.size() > 0 && !sender_pause()) begin
					nxt      = pending_ops.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= nxt.fields;
					s_tuser  <= nxt.op;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each result transaction against the oldest prediction
	always @(posedge clk or negedge arst_n) begin : watch_results
		out_item_t got;
		out_item_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = out_item_t'(m_tdata);
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h", $time, got);
					errors++;
				end else begin
					want = expected_results.pop_front();
					check_field("key_found", 16'(want.key_found), 16'(got.key_found));
					check_field("score_usable", 16'(want.score_usable), 16'(got.score_usable));
					check_field("found_score", want.found_score, got.found_score);
					check_field("found_move", want.found_move, got.found_move);
				end
			end
			m_tready <= !receiver_stall();
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin : stimulus
		logic [KEY_W-1:0] k;
		logic [KEY_W-1:0] k_lower;
		logic [KEY_W-1:0] k_upper;
		logic [KEY_W-1:0] k_odd;
		logic [KEY_W-1:0] k_rival;
		logic [15:0]      sc;
		logic [7:0]       dp;
		logic [1:0]       bd;
		for (int i = 0; i < SLOTS; i++)
			shadow_table[i] = '0;
		for (int i = 0; i < 24; i++) begin
			key_pool[i] = {$urandom, $urandom};
			key_pool[i][INDEX_BITS_DEF-1:0] = INDEX_BITS_DEF'(i % 8 + 8);
		end
		k_lower = {32'h1234_5678, 32'h9abc_d001};
		k_upper = {32'h0f0f_0f0f, 32'hf0f0_f002};
		k_odd   = {32'h5555_aaaa, 32'h5555_a003};
		k_rival = {32'hdead_0000, 32'h0000_0002};

		// directed: empty table, key zero, field extremes, bound rules, replacement
		queue_op(OP_PROBE, '0, 16'h8000, 16'h7fff, 8'h80, '0, BOUND_EXACT, '0);
		queue_op(OP_STORE, '0, '0, '0, 8'd5, 16'h0123, BOUND_EXACT, 16'h4444);
		queue_op(OP_PROBE, '0, 16'h8000, 16'h7fff, 8'h80, '0, BOUND_EXACT, '0);
		queue_op(OP_STORE, '1, 16'h7fff, 16'h8000, 8'h7f, 16'h7fff, BOUND_EXACT, 16'hffff);
		queue_op(OP_PROBE, '1, 16'h7fff, 16'h8000, 8'h7f, '1, 2'd3, '1);
		queue_op(OP_PROBE, '1, 16'h8000, 16'h7fff, 8'h80, '0, BOUND_EXACT, '0);
		// negative store depth is clamped to zero
		queue_op(OP_STORE, k_lower, '0, '0, 8'h80, 16'h8000, BOUND_LOWER, 16'h0000);
		queue_op(OP_PROBE, k_lower, '0, 16'h8000, 8'd0, '0, BOUND_EXACT, '0);
		queue_op(OP_PROBE, k_lower, '0, 16'h7fff, 8'd0, '0, BOUND_EXACT, '0);
		queue_op(OP_PROBE, k_lower, '0, 16'h8000, 8'd1, '0, BOUND_EXACT, '0);
		queue_op(OP_STORE, k_upper, '0, '0, 8'd3, 16'd100, BOUND_UPPER, 16'h0a0a);
		queue_op(OP_PROBE, k_upper, 16'd100, '0, 8'd3, '0, BOUND_EXACT, '0);
		queue_op(OP_PROBE, k_upper, 16'd99, '0, 8'd3, '0, BOUND_EXACT, '0);
		queue_op(OP_PROBE, k_upper, 16'h7fff, '0, 8'd4, '0, BOUND_EXACT, '0);
		// bound kind three keeps the move but never the score
		queue_op(OP_STORE, k_odd, '0, '0, 8'd10, 16'd7, 2'd3, 16'h3c3c);
		queue_op(OP_PROBE, k_odd, 16'h7fff, 16'h8000, 8'h80, '0, BOUND_EXACT, '0);
		// same key: shallower exact replaces, shallower non-exact does not
		queue_op(OP_STORE, k_upper, '0, '0, 8'd1, 16'd55, BOUND_EXACT, 16'h0b0b);
		queue_op(OP_STORE, k_upper, '0, '0, 8'd0, 16'd66, BOUND_LOWER, 16'h0c0c);
		queue_op(OP_PROBE, k_upper, '0, '0, 8'd1, '0, BOUND_EXACT, '0);
		// different key in the same slot needs at least the stored depth
		queue_op(OP_STORE, k_rival, '0, '0, 8'd0, 16'd9, BOUND_EXACT, 16'h0d0d);
		queue_op(OP_PROBE, k_upper, '0, '0, 8'd0, '0, BOUND_EXACT, '0);
		queue_op(OP_STORE, k_rival, '0, '0, 8'd2, 16'd9, BOUND_EXACT, 16'h0e0e);
		queue_op(OP_PROBE, k_upper, '0, '0, 8'd0, '0, BOUND_EXACT, '0);
		queue_op(OP_PROBE, k_rival, '0, '0, 8'd2, '0, BOUND_EXACT, '0);

		// random: store then probe the same key with windows near the score, plus noise
		while (pending_ops.size() < RANDOM_OPS + 24) begin
			if ($urandom_range(99) < 70) begin
				k  = pick_key();
				sc = 16'($urandom);
				dp = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(24) - 4);
				bd = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
				queue_op(OP_STORE, k, 16'($urandom), 16'($urandom), dp, sc, bd,
					16'($urandom));
				repeat ($urandom_range(1, 3))
					queue_op(OP_PROBE, k, 16'(sc + $urandom_range(8) - 4),
						16'(sc + $urandom_range(8) - 4), 8'(dp + $urandom_range(6) - 3),
						16'($urandom), 2'($urandom), 16'($urandom));
			end else begin
				k = ($urandom_range(19) == 0) ? '0 : pick_key();
				queue_op(1'($urandom), k, 16'($urandom), 16'($urandom), 8'($urandom),
					16'($urandom), 2'($urandom), 16'($urandom));
			end
		end
		total_ops = pending_ops.size();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (n_sent != total_ops || expected_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

[files.f]
hdl/srht_pkg.sv
hdl/srht_ram.sv
hdl/srht_ctrl.sv
hdl/srht_dp.sv
hdl/search_result_hash_table_unit.sv
tb/search_result_hash_table_unit_tb.sv
